FILE: rtl/core/sccpt_pkg.sv
// Shared types, command codes and helper functions for the serial calendar clock.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package sccpt_pkg;

   localparam logic [23:0] CPS_RESET     = 24'd12000000;
   localparam int          DATA_BITS     = 48;
   localparam int          CYCLE_BITS    = 25;
   localparam int          INTERVAL_BITS = 30;
   localparam int          COUNTER_BITS  = 32;

   typedef enum logic [3:0] {
      CMD_HOLD       = 4'h0,
      CMD_SHIFT      = 4'h1,
      CMD_SET        = 4'h2,
      CMD_READ       = 4'h3,
      CMD_TP_64      = 4'h4,
      CMD_TP_256     = 4'h5,
      CMD_TP_2048    = 4'h6,
      CMD_TP_4096    = 4'h7,
      CMD_INT_1S     = 4'h8,
      CMD_INT_10S    = 4'h9,
      CMD_INT_30S    = 4'hA,
      CMD_INT_60S    = 4'hB,
      CMD_FLAG_RESET = 4'hC,
      CMD_INT_RUN    = 4'hD,
      CMD_INT_STOP   = 4'hE,
      CMD_TEST       = 4'hF
   } cmd_type;

   typedef struct packed {
      logic        run;      // execute cmd on this transaction
      cmd_type     cmd;
      logic        advance;  // time advance on this transaction
      logic [15:0] cycles;
   } timer_ctrl_type;

   typedef struct packed {
      logic tick;         // one second elapsed on this transaction
      logic half_level;   // 1 Hz level after the update
      logic pulse_level;  // timing pulse level after the update
   } timer_stat_type;

   typedef struct packed {
      logic set;
      logic tick;
   } cal_ctrl_type;

   typedef struct packed {
      logic pulse_out;
      logic data_out;
   } rsp_type;

   // Two BCD-style digits to a count, with no range check on the digits.
   function automatic logic [7:0] digits_to_count(input logic [3:0] hi, input logic [3:0] lo);
      logic [7:0] h;
      h = {4'b0, hi};
      return (h << 3) + (h << 1) + {4'b0, lo};
   endfunction

   // Splits a count into {tens, ones}; tens may reach 25 and spill past a nibble.
   function automatic logic [8:0] count_to_digits(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  tens;
      logic [7:0]  tens_x10;
      logic [7:0]  ones;
      prod     = {8'b0, v} * 16'd205;
      tens     = prod[15:11];
      tens_x10 = ({3'b0, tens} << 3) + ({3'b0, tens} << 1);
      ones     = v - tens_x10;
      return {tens, ones[3:0]};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sccpt_calendar.sv
// Calendar counters: second through year, with time set and time read word.
// Depends on sccpt_pkg for the control struct and digit helpers.
`default_nettype none

module sccpt_calendar
   import sccpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cal_ctrl_type         ctrl,
   input  wire logic [DATA_BITS-1:0] set_word,
   output logic      [DATA_BITS-1:0] read_word
);

   logic [7:0] second_ff, second_in;
   logic [7:0] minute_ff, minute_in;
   logic [7:0] hour_ff, hour_in;
   logic [7:0] day_ff, day_in;
   logic [3:0] weekday_ff, weekday_in;
   logic [3:0] month_ff, month_in;
   logic [7:0] year_ff, year_in;

   function automatic logic [7:0] month_length(input logic [3:0] m, input logic [7:0] y);
      logic [7:0] len;
      unique case (m)
         4'd2:                      len = (y[1:0] == 2'b00) ? 8'd29 : 8'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 8'd30;
         default:                   len = 8'd31;
      endcase
      return len;
   endfunction

   always_comb begin
      logic [7:0] s1, m1, h1, d1, y1;
      logic [4:0] w1, mo1;
      second_in  = second_ff;
      minute_in  = minute_ff;
      hour_in    = hour_ff;
      day_in     = day_ff;
      weekday_in = weekday_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      s1  = second_ff + 8'd1;
      m1  = minute_ff + 8'd1;
      h1  = hour_ff + 8'd1;
      d1  = day_ff + 8'd1;
      y1  = year_ff + 8'd1;
      w1  = {1'b0, weekday_ff} + 5'd1;
      mo1 = {1'b0, month_ff} + 5'd1;
      if (ctrl.set) begin
         second_in  = digits_to_count(set_word[7:4], set_word[3:0]);
         minute_in  = digits_to_count(set_word[15:12], set_word[11:8]);
         hour_in    = digits_to_count(set_word[23:20], set_word[19:16]);
         day_in     = digits_to_count(set_word[31:28], set_word[27:24]);
         weekday_in = set_word[35:32];
         month_in   = set_word[39:36];
         year_in    = digits_to_count(set_word[47:44], set_word[43:40]);
      end else if (ctrl.tick) begin
         // Each unit carries only when the one below it has wrapped.
         if (s1 < 8'd60) begin
            second_in = s1;
         end else begin
            second_in = 8'd0;
            if (m1 < 8'd60) begin
               minute_in = m1;
            end else begin
               minute_in = 8'd0;
               if (h1 < 8'd24) begin
                  hour_in = h1;
               end else begin
                  hour_in    = 8'd0;
                  weekday_in = (w1 >= 5'd7) ? 4'd0 : w1[3:0];
                  if (d1 <= month_length(month_ff, year_ff)) begin
                     day_in = d1;
                  end else begin
                     day_in = 8'd1;
                     if (mo1 <= 5'd12) begin
                        month_in = mo1[3:0];
                     end else begin
                        month_in = 4'd1;
                        year_in  = (y1 >= 8'd100) ? 8'd0 : y1;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      logic [8:0]  sd, md, hd, dd, yd;
      logic [55:0] word;
      sd = count_to_digits(second_ff);
      md = count_to_digits(minute_ff);
      hd = count_to_digits(hour_ff);
      dd = count_to_digits(day_ff);
      yd = count_to_digits(year_ff);
      // Tens above 15 overlap the next field and are ORed into it.
      word = ({47'b0, sd}) | ({47'b0, md} << 8) | ({47'b0, hd} << 16) |
             ({47'b0, dd} << 24) | ({52'b0, weekday_ff} << 32) |
             ({52'b0, month_ff} << 36) | ({47'b0, yd} << 40);
      read_word = word[DATA_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff  <= 8'd0;
         minute_ff  <= 8'd0;
         hour_ff    <= 8'd0;
         day_ff     <= 8'd1;
         weekday_ff <= 4'd0;
         month_ff   <= 4'd1;
         year_ff    <= 8'd0;
      end else begin
         second_ff  <= second_in;
         minute_ff  <= minute_in;
         hour_ff    <= hour_in;
         day_ff     <= day_in;
         weekday_ff <= weekday_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/sccpt_timer.sv
// Second divider, 1 Hz level and timing-pulse generator with its interval commands.
// Depends on sccpt_pkg for the control and status structs.
`default_nettype none

module sccpt_timer
   import sccpt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [23:0]    cycles_per_second,
   input  wire timer_ctrl_type ctrl,
   output timer_stat_type      stat
);

   logic [CYCLE_BITS-1:0]    second_cycles_ff, second_cycles_in;
   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;
   logic [COUNTER_BITS-1:0]  counter_ff, counter_in;
   logic                     stopped_ff, stopped_in;
   logic                     half_ff, half_in;
   logic                     level_ff, level_in;
   logic                     tick;

   always_comb begin
      logic [INTERVAL_BITS-1:0] cps;
      logic [CYCLE_BITS:0]      sum;
      logic [CYCLE_BITS:0]      sum_adj;
      logic [COUNTER_BITS-1:0]  cnt;
      second_cycles_in = second_cycles_ff;
      interval_in      = interval_ff;
      counter_in       = counter_ff;
      stopped_in       = stopped_ff;
      half_in          = half_ff;
      level_in         = level_ff;
      tick             = 1'b0;
      cps     = {6'b0, cycles_per_second};
      sum     = {1'b0, second_cycles_ff} + {10'b0, ctrl.cycles};
      sum_adj = sum;
      cnt     = counter_ff + {16'b0, ctrl.cycles};
      if (ctrl.run) begin
         unique case (ctrl.cmd)
            CMD_HOLD:       interval_in = cps >> 6;
            CMD_TP_64: begin
               interval_in = cps >> 6;
               stopped_in  = 1'b0;
            end
            CMD_TP_256: begin
               interval_in = cps >> 8;
               stopped_in  = 1'b0;
            end
            CMD_TP_2048: begin
               interval_in = cps >> 11;
               stopped_in  = 1'b0;
            end
            CMD_TP_4096: begin
               interval_in = cps >> 12;
               stopped_in  = 1'b0;
            end
            CMD_INT_1S: begin
               interval_in = cps;
               counter_in  = '0;
               stopped_in  = 1'b0;
            end
            CMD_INT_10S: begin
               interval_in = (cps << 3) + (cps << 1);
               counter_in  = '0;
               stopped_in  = 1'b0;
            end
            CMD_INT_30S: begin
               interval_in = (cps << 5) - (cps << 1);
               counter_in  = '0;
               stopped_in  = 1'b0;
            end
            CMD_INT_60S: begin
               interval_in = (cps << 6) - (cps << 2);
               counter_in  = '0;
               stopped_in  = 1'b0;
            end
            CMD_FLAG_RESET: begin
               level_in   = 1'b0;
               stopped_in = 1'b0;
            end
            CMD_INT_RUN: begin
               counter_in = '0;
               stopped_in = 1'b0;
            end
            CMD_INT_STOP:   stopped_in = 1'b1;
            default: ;
         endcase
      end else if (ctrl.advance) begin
         // At most one second is taken out per transaction; the remainder wraps.
         if (sum >= {2'b0, cycles_per_second}) begin
            tick    = 1'b1;
            sum_adj = sum - {2'b0, cycles_per_second};
         end
         second_cycles_in = sum_adj[CYCLE_BITS-1:0];
         half_in = (second_cycles_in >= {2'b0, cycles_per_second[23:1]});
         if (!stopped_ff) begin
            if (cnt >= {2'b0, interval_ff}) begin
               cnt = cnt - {2'b0, interval_ff};
            end
            counter_in = cnt;
            level_in   = (cnt >= {3'b0, interval_ff[INTERVAL_BITS-1:1]});
         end
      end
   end

   assign stat.tick        = tick;
   assign stat.half_level  = half_in;
   assign stat.pulse_level = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_cycles_ff <= '0;
         interval_ff      <= {6'b0, CPS_RESET};
         counter_ff       <= '0;
         stopped_ff       <= 1'b0;
         half_ff          <= 1'b0;
         level_ff         <= 1'b0;
      end else begin
         second_cycles_ff <= second_cycles_in;
         interval_ff      <= interval_in;
         counter_ff       <= counter_in;
         stopped_ff       <= stopped_in;
         half_ff          <= half_in;
         level_ff         <= level_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/sccpt_out_buffer.sv
// Two-entry result buffer: an output register plus a skid register.
// Depends on sccpt_pkg for the result struct.
`default_nettype none

module sccpt_out_buffer
   import sccpt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_ready
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         // Output is stalled; park the new result behind it.
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/serial_calendar_clock_with_pulse_timer_core.sv
// Top level of the serial calendar clock: serial port, command decode and result stream.
// Depends on sccpt_pkg, sccpt_calendar, sccpt_timer and sccpt_out_buffer.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata pin_data, cycles; tuser func
//   rsp      out        rsp_tvalid/rsp_tready  tdata data_out, pulse_out
//   csr      in         csr_valid/csr_ready    csr_data cycles_per_second
//
// One transaction per cycle while req_tready is high: every item updates all state in the
// cycle it is taken, through the calendar carry chain and the pulse counter add and compare.
// Its result reaches rsp through the output register, by way of the skid register on a stall.
// A stalled rsp side fills the skid register; req_tready drops only when both are full.
// Reset is synchronous; the calendar reads 00-01-01 00:00:00 after it.
`default_nettype none

module serial_calendar_clock_with_pulse_timer_core
   import sccpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [2:0] pin_data, [18:3] cycles, rest zero
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] data_out, [1] pulse_out, rest zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [23:0] csr_data
);

   typedef enum logic [1:0] {
      MODE_HOLD  = 2'd0,
      MODE_SHIFT = 2'd1,
      MODE_SET   = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   logic [23:0]          cps_ff;
   logic [3:0]           command_ff, command_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   mode_type             mode_ff, mode_in;
   logic                 last_clk_ff, last_clk_in;
   logic                 last_stb_ff, last_stb_in;

   logic                 accept;
   logic                 pin_write;
   logic                 stb_rise;
   logic                 clk_rise;
   cmd_type              cmd;
   timer_ctrl_type       timer_ctrl;
   timer_stat_type       timer_stat;
   cal_ctrl_type         cal_ctrl;
   logic [DATA_BITS-1:0] read_word;
   rsp_type              rsp_next;
   rsp_type              rsp_data;

   assign accept    = req_tvalid && req_tready;
   assign pin_write = accept && !req_tuser;
   assign stb_rise  = !last_stb_ff && req_tdata[2];
   assign clk_rise  = !last_clk_ff && req_tdata[1];
   assign cmd       = cmd_type'(command_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      command_in  = command_ff;
      data_in     = data_ff;
      mode_in     = mode_ff;
      last_clk_in = last_clk_ff;
      last_stb_in = last_stb_ff;
      if (pin_write) begin
         last_clk_in = req_tdata[1];
         last_stb_in = req_tdata[2];
         if (stb_rise) begin
            unique case (cmd)
               CMD_HOLD:  mode_in = MODE_HOLD;
               CMD_SHIFT: mode_in = MODE_SHIFT;
               CMD_SET:   mode_in = MODE_SET;
               CMD_READ: begin
                  mode_in = MODE_READ;
                  data_in = read_word;
               end
               default: ;
            endcase
         end else if (!req_tdata[2] && clk_rise) begin
            // The bit leaving the command register feeds the data register in shift mode.
            command_in = {req_tdata[0], command_ff[3:1]};
            if (mode_ff == MODE_SHIFT) begin
               data_in = {command_ff[0], data_ff[DATA_BITS-1:1]};
            end
         end
      end
   end

   assign timer_ctrl.run     = pin_write && stb_rise;
   assign timer_ctrl.cmd     = cmd;
   assign timer_ctrl.advance = accept && req_tuser;
   assign timer_ctrl.cycles  = req_tdata[18:3];

   assign cal_ctrl.set  = pin_write && stb_rise && (cmd == CMD_SET);
   assign cal_ctrl.tick = timer_stat.tick;

   assign rsp_next.data_out  = (mode_in == MODE_HOLD || mode_in == MODE_READ) ?
                               timer_stat.half_level : data_in[0];
   assign rsp_next.pulse_out = timer_stat.pulse_level;

   sccpt_timer u_timer (
      .clock             (clock),
      .reset             (reset),
      .cycles_per_second (cps_ff),
      .ctrl              (timer_ctrl),
      .stat              (timer_stat)
   );

   sccpt_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cal_ctrl),
      .set_word  (data_ff),
      .read_word (read_word)
   );

   sccpt_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (rsp_next),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {6'b0, rsp_data.pulse_out, rsp_data.data_out};

   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff      <= CPS_RESET;
         command_ff  <= 4'd0;
         data_ff     <= '0;
         mode_ff     <= MODE_HOLD;
         last_clk_ff <= 1'b0;
         last_stb_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cps_ff <= csr_data;
         end
         command_ff  <= command_in;
         data_ff     <= data_in;
         mode_ff     <= mode_in;
         last_clk_ff <= last_clk_in;
         last_stb_ff <= last_stb_in;
      end
   end

endmodule

`default_nettype wire
